// ===== design/rsrs_pkg.sv =====
package rsrs_pkg;

	// Pixel and register widths
	localparam int PIX_W      = 8;
	localparam int FW_W       = 12;
	localparam int FH_W       = 12;
	localparam int YAW_W      = 24;
	localparam int READOUT_W  = 25;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READOUT_TIME = 2'd3;

	// Shift arithmetic: dx = yaw * readout * 100 * row / (height * 2^40)
	localparam int K_SCALE     = 100;
	localparam int K_W         = 7;
	localparam int SHIFT_FRAC  = 40;
	localparam int SHIFT_MAG_W = 23;

	// Result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             flush;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_end;
		logic             frame_end;
	} out_word_t;

	// Tag of a store read in flight
	typedef struct packed {
		logic valid;
		logic row_end;
		logic frame_end;
	} rd_tag_t;

	// Request to the shift unit
	typedef struct packed {
		logic                 restart;
		logic                 neg;
		logic [YAW_W-1:0]     ay;
		logic [READOUT_W-1:0] rt;
	} shift_cmd_t;

	// Shift unit result
	typedef struct packed {
		logic                   ok;
		logic                   neg;
		logic [SHIFT_MAG_W-1:0] mag;
	} shift_res_t;

endpackage

// ===== design/rsrs_stream_if.sv =====
interface rsrs_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/rsrs_ram.sv =====
module rsrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/rsrs_shift.sv =====
module rsrs_shift #(
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsrs_pkg::shift_cmd_t          cmd,
	input  logic [$clog2(MAX_HEIGHT)-1:0]   row,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
	output rsrs_pkg::shift_res_t          res
);
	import rsrs_pkg::*;

	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW    = YAW_W + READOUT_W + K_W + RW;
	localparam int QW    = PW - SHIFT_FRAC;
	localparam int MW    = (RW > READOUT_W) ? RW : READOUT_W;
	localparam int STEPS = (QW > MW) ? QW : MW;
	localparam int CNTW  = $clog2(STEPS + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MUL_RT,
		ST_MUL_K,
		ST_MUL_ROW,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [PW-1:0]   acc_q;
	logic [PW-1:0]   mcand_q;
	logic [MW-1:0]   mult_q;
	logic [CNTW-1:0] cnt_q;
	logic [QW-1:0]   dq_q;
	logic [HW-1:0]   rem_q;
	logic [HW-1:0]   h_q;
	logic [RW-1:0]   row_q;
	logic            neg_q;

	logic [PW-1:0]   acc_nx;
	logic [HW:0]     trial;
	logic            ge;
	logic [HW-1:0]   rem_nx;
	logic            last_step;

	// shift-add multiply step and restoring divide step
	always_comb begin
		acc_nx    = acc_q + (mult_q[0] ? mcand_q : '0);
		trial     = {rem_q, dq_q[QW-1]};
		ge        = (trial >= {1'b0, h_q});
		rem_nx    = ge ? HW'(trial - {1'b0, h_q}) : HW'(trial);
		last_step = (cnt_q == CNTW'(1));
	end

	// sequencer: |yaw| * readout, * 100, * row, then >> 40 and / height
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else if (cmd.restart) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					acc_q   <= '0;
					mcand_q <= PW'(cmd.ay);
					mult_q  <= MW'(cmd.rt);
					cnt_q   <= CNTW'(READOUT_W);
					neg_q   <= cmd.neg;
					row_q   <= row;
					h_q     <= height;
					state_q <= ST_MUL_RT;
				end
				ST_MUL_RT, ST_MUL_K, ST_MUL_ROW: begin
					acc_q   <= acc_nx;
					mcand_q <= mcand_q << 1;
					mult_q  <= mult_q >> 1;
					cnt_q   <= cnt_q - CNTW'(1);
					if (last_step) begin
						case (state_q)
							ST_MUL_RT: begin
								mcand_q <= acc_nx;
								acc_q   <= '0;
								mult_q  <= MW'(K_SCALE);
								cnt_q   <= CNTW'(K_W);
								state_q <= ST_MUL_K;
							end
							ST_MUL_K: begin
								mcand_q <= acc_nx;
								acc_q   <= '0;
								mult_q  <= MW'(row_q);
								cnt_q   <= CNTW'(RW);
								state_q <= ST_MUL_ROW;
							end
							default: begin
								dq_q    <= acc_nx[PW-1:SHIFT_FRAC];
								rem_q   <= '0;
								cnt_q   <= CNTW'(QW);
								state_q <= ST_DIV;
							end
						endcase
					end
				end
				ST_DIV: begin
					dq_q  <= {dq_q[QW-2:0], ge};
					rem_q <= rem_nx;
					cnt_q <= cnt_q - CNTW'(1);
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// saturate the magnitude
	always_comb begin
		res.ok  = (state_q == ST_DONE);
		res.neg = neg_q;
		if ((dq_q >> SHIFT_MAG_W) != '0) begin
			res.mag = '1;
		end else begin
			res.mag = SHIFT_MAG_W'(dq_q);
		end
	end

	a_restart_clears_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.restart |=> !res.ok)
		else $error("shift result still marked valid after restart");
endmodule

// ===== design/rsrs_front.sv =====
module rsrs_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	rsrs_stream_if.sink                       pixel_stream,
	input  logic [rsrs_pkg::QCW-1:0]          q_count,
	input  rsrs_pkg::shift_res_t              shift_res,
	output rsrs_pkg::shift_cmd_t              shift_cmd,
	output logic [$clog2(MAX_HEIGHT)-1:0]     shift_row,
	output logic [$clog2(MAX_HEIGHT+1)-1:0]   shift_height,
	output logic                              ram_we,
	output logic [$clog2(MAX_WIDTH):0]        ram_waddr,
	output logic [rsrs_pkg::PIX_W-1:0]        ram_wdata,
	output logic                              ram_re,
	output logic [$clog2(MAX_WIDTH):0]        ram_raddr,
	output rsrs_pkg::rd_tag_t                 tag_s1
);
	import rsrs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	localparam logic [FW_W-1:0] FW_RST = FW_W'(640);
	localparam logic [FH_W-1:0] FH_RST = FH_W'(480);

	logic [FW_W-1:0]        fw_q;
	logic [FH_W-1:0]        fh_q;
	logic [YAW_W-1:0]       yaw_q;
	logic [READOUT_W-1:0]   rt_q;
	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic                   bank_q;
	logic                   pend_q;
	logic                   plast_q;
	logic                   sneg_q;
	logic [SHIFT_MAG_W-1:0] smag_q;

	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic [WW-1:0] x1;
	logic          last_col;
	logic [RW-1:0] hm1;
	logic [RW-1:0] r;
	logic          row_last;
	logic          shift_on;
	logic [CW-1:0] m;
	logic [WW-1:0] lim;
	logic [CW-1:0] s;
	logic [QCW:0]  occ;
	logic          space_ok;
	logic          acc;
	logic          flush;
	logic          row_done;
	logic          flush_done;

	// effective width and height, row position
	always_comb begin
		if (fw_q == '0) begin
			w = WW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(fw_q);
		end
		if (fh_q == '0) begin
			h = HW'(1);
		end else if (32'(fh_q) > MAX_HEIGHT) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(fh_q);
		end
		x1       = WW'(col_q) + WW'(1);
		last_col = (x1 >= w);
		hm1      = RW'(h - HW'(1));
		r        = (row_q > hm1) ? hm1 : row_q;
		row_last = (r == hm1);
	end

	// source column in the pending row
	always_comb begin
		shift_on = (smag_q != '0) && (32'(smag_q) < 32'(w));
		m        = CW'(smag_q);
		lim      = w - WW'(m);
		s        = col_q;
		if (shift_on) begin
			if (!sneg_q) begin
				if (col_q >= m) begin
					s = col_q - m;
				end
			end else begin
				if (WW'(col_q) < lim) begin
					s = col_q + m;
				end
			end
		end
	end

	// accept when the queue has room and the row shift is ready at row end
	always_comb begin
		occ                = {1'b0, q_count} + (QCW+1)'(tag_s1.valid);
		space_ok           = (occ < (QCW+1)'(QDEPTH));
		pixel_stream.ready = space_ok && (!last_col || shift_res.ok);
		acc                = pixel_stream.valid && pixel_stream.ready;
		flush              = pixel_stream.data.flush;
		row_done           = acc && !flush && last_col;
		flush_done         = acc && flush && pend_q && last_col;
	end

	// store access
	always_comb begin
		ram_we    = acc && !flush;
		ram_waddr = {bank_q, col_q};
		ram_wdata = pixel_stream.data.pixel_in;
		ram_re    = acc && pend_q;
		ram_raddr = {~bank_q, s};
	end

	// shift unit request for the row being written
	always_comb begin
		shift_cmd.restart = cfg_we || row_done || flush_done;
		shift_cmd.neg     = yaw_q[YAW_W-1];
		shift_cmd.ay      = yaw_q[YAW_W-1] ? (~yaw_q + YAW_W'(1)) : yaw_q;
		shift_cmd.rt      = rt_q;
		shift_row         = r;
		shift_height      = h;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_RST;
			fh_q  <= FH_RST;
			yaw_q <= '0;
			rt_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q  <= cfg_data[FH_W-1:0];
				REG_YAW_RATE:     yaw_q <= cfg_data[YAW_W-1:0];
				REG_READOUT_TIME: rt_q  <= cfg_data[READOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// row and frame sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			bank_q  <= 1'b0;
			pend_q  <= 1'b0;
			plast_q <= 1'b0;
			sneg_q  <= 1'b0;
			smag_q  <= '0;
			tag_s1  <= '0;
		end else begin
			tag_s1.valid     <= ram_re;
			tag_s1.row_end   <= last_col;
			tag_s1.frame_end <= last_col && plast_q;
			if (acc) begin
				if (flush) begin
					if (pend_q) begin
						if (last_col) begin
							pend_q  <= 1'b0;
							plast_q <= 1'b0;
							col_q   <= '0;
							row_q   <= '0;
						end else begin
							col_q <= CW'(x1);
						end
					end
				end else if (last_col) begin
					sneg_q  <= shift_res.neg;
					smag_q  <= shift_res.mag;
					pend_q  <= 1'b1;
					plast_q <= row_last;
					row_q   <= row_last ? '0 : RW'(r + RW'(1));
					bank_q  <= ~bank_q;
					col_q   <= '0;
				end else begin
					col_q <= CW'(x1);
				end
			end
		end
	end

	a_row_end_has_shift: assert property (@(posedge clk) disable iff (!arst_n)
		row_done |-> shift_res.ok)
		else $error("row closed without a finished shift");

	a_bank_swaps_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		row_done |=> (bank_q != $past(bank_q)) && pend_q)
		else $error("bank did not swap at row end");
endmodule

// ===== design/rsrs_back.sv =====
module rsrs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rsrs_pkg::rd_tag_t           tag_s1,
	input  logic [rsrs_pkg::PIX_W-1:0]  rdata,
	rsrs_stream_if.source               result_stream,
	output logic [rsrs_pkg::QCW-1:0]    q_count
);
	import rsrs_pkg::*;

	out_word_t      q_mem [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	always_comb begin
		result_stream.valid  = (cnt_q != '0);
		result_stream.data   = q_mem[rp_q];
		push                 = tag_s1.valid;
		pop                  = result_stream.valid && result_stream.ready;
		q_count              = cnt_q;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= '{pixel_out: rdata, row_end: tag_s1.row_end,
				frame_end: tag_s1.frame_end};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= QAW'(wp_q + QAW'(1));
			end
			if (pop) begin
				rp_q <= QAW'(rp_q + QAW'(1));
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != QCW'(QDEPTH)))
		else $error("word pushed into a full queue");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("queue count beyond depth");
endmodule

// ===== design/rolling_shutter_row_shift.sv =====
// Horizontal rolling shutter correction for a luma raster stream. Each input word
// carries one pixel (or a flush); each row is stored in one bank of a two-bank row
// store (2 x 2^clog2(MAX_WIDTH) bytes) and played back during the next row with a
// per-row shift dx = trunc(yaw_rate * readout_time * 100 * row / (height * 2^40)),
// so output lags input by one row, and flush words drain the last row. Throughput is
// one pixel per clock while the result side keeps up and the row shift is ready; an
// accepted pixel's result passes through the registered store read into the four-word
// output queue, and input stalls while that queue, with the read in flight, is full.
// The shift is produced by a serial multiply/divide unit that restarts when the
// previous row closes; the last pixel of a row is held off until it finishes, and so
// is the last pixel of the first row after a register write, which also restarts it.
// Registers are to be written only while the block is idle. The store is not cleared
// after reset.
module rolling_shutter_row_shift #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsrs_pkg::CFG_DATA_W-1:0] cfg_data,
	rsrs_stream_if.sink                     pixel_stream,
	rsrs_stream_if.source                   result_stream
);
	import rsrs_pkg::*;

	localparam int CW          = $clog2(MAX_WIDTH);
	localparam int STORE_DEPTH = 2 * (1 << CW);

	shift_cmd_t                      shift_cmd;
	shift_res_t                      shift_res;
	rd_tag_t                         tag_s1;
	logic [$clog2(MAX_HEIGHT)-1:0]   shift_row;
	logic [$clog2(MAX_HEIGHT+1)-1:0] shift_height;
	logic                            ram_we;
	logic [CW:0]                     ram_waddr;
	logic [PIX_W-1:0]                ram_wdata;
	logic                            ram_re;
	logic [CW:0]                     ram_raddr;
	logic [PIX_W-1:0]                ram_rdata;
	logic [QCW-1:0]                  q_count;

	rsrs_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_stream (pixel_stream),
		.q_count      (q_count),
		.shift_res    (shift_res),
		.shift_cmd    (shift_cmd),
		.shift_row    (shift_row),
		.shift_height (shift_height),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.tag_s1       (tag_s1)
	);

	rsrs_shift #(
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (shift_cmd),
		.row    (shift_row),
		.height (shift_height),
		.res    (shift_res)
	);

	rsrs_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rsrs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.tag_s1        (tag_s1),
		.rdata         (ram_rdata),
		.result_stream (result_stream),
		.q_count       (q_count)
	);
endmodule
